// ----- rtl/process_ready_queue_core_assert.svh -----
// Assertion macros used by the checker file of the ready queue.
`ifndef PROCESS_READY_QUEUE_CORE_ASSERT_SVH
`define PROCESS_READY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PRQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("process_ready_queue_core: check failed");

// Next-cycle implication, disabled during reset.
`define PRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("process_ready_queue_core: check failed");

`endif

// ----- rtl/prq_pkg.sv -----
`timescale 1ns / 1ps

package prq_pkg;

   localparam int ID_W   = 16;
   localparam int DESC_W = 32;

   typedef enum logic [1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   // Sequencer phases, one-hot.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_MATCH = 4'b0010,
      PH_PICK  = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              match_en;
      logic              pick_en;
      logic              apply_en;
      logic              any_key;
      logic [ID_W-1:0]   key;
      logic              do_shift;
      logic              do_enq;
      logic [ID_W-1:0]   enq_id;
      logic [DESC_W-1:0] enq_desc;
   } cell_ctl_type;

endpackage

// ----- rtl/prq_if.sv -----
`timescale 1ns / 1ps

interface prq_req_if import prq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [ID_W-1:0]   proc_id;
   logic [DESC_W-1:0] descriptor;

   modport source (output valid, op, proc_id, descriptor, input ready);
   modport sink   (input valid, op, proc_id, descriptor, output ready);
endinterface

interface prq_rsp_if import prq_pkg::*; #(parameter int OCC_W = 5);
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ID_W-1:0]   out_id;
   logic [DESC_W-1:0] out_descriptor;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, status, out_id, out_descriptor, occupancy, input ready);
   modport sink   (input valid, status, out_id, out_descriptor, occupancy, output ready);
endinterface

// ----- rtl/process_ready_queue_core.sv -----
`timescale 1ns / 1ps

// Bounded FIFO of process entries (16-bit identifier plus 32-bit descriptor)
// with enqueue, dequeue, remove-first-match and lookup-first-match, built as a
// row of CAPACITY cells that each hold one entry, packed from the head at cell
// 0. An item passes through four steps from accept to result: it is accepted,
// every cell compares its identifier with the key in parallel, the "earlier
// match" flag ripples down the row and marks the first match, and the cells
// behind that match shift toward the head (or the first empty cell is loaded
// on enqueue) while the result is loaded into the output register. The
// next beat is taken as soon as the previous result sits in the output
// register; a stalled result only holds the final step of the following item.
// Each result carries a status, the dequeued, removed or found entry (zero on
// enqueue or failure) and the occupancy after the operation. Stored entries
// need no clearing after reset.
module process_ready_queue_core import prq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   prq_req_if.sink   req,
   prq_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer and captured request
   phase_type         phase_ff, phase_in;
   op_type            op_ff;
   logic [ID_W-1:0]   key_ff;
   logic [DESC_W-1:0] desc_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              any_hit_ff;

   // Output register
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   out_id_ff;
   logic [DESC_W-1:0] out_desc_ff;

   cell_ctl_type      ctl;
   logic              accept;
   logic              out_free;
   logic              apply;
   logic              full;
   logic              empty;

   // Row wiring
   logic              cell_valid [CAPACITY];
   logic [ID_W-1:0]   cell_id    [CAPACITY];
   logic [DESC_W-1:0] cell_desc  [CAPACITY];
   logic [ID_W-1:0]   sel_id     [CAPACITY];
   logic [DESC_W-1:0] sel_desc   [CAPACITY];
   logic              hit        [CAPACITY + 1];
   logic [ID_W-1:0]   pick_id;
   logic [DESC_W-1:0] pick_desc;

   assign accept   = req.valid & req.ready;
   assign out_free = ~rsp_valid_ff | rsp.ready;
   assign apply    = (phase_ff == PH_DONE) & out_free;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);

   assign req.ready = (phase_ff == PH_IDLE);

   // Advance through compare, pick and apply; hold in apply while the output stalls.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:  if (accept) phase_in = PH_MATCH;
         PH_MATCH: phase_in = PH_PICK;
         PH_PICK:  phase_in = PH_DONE;
         PH_DONE:  if (out_free) phase_in = PH_IDLE;
         default:  phase_in = PH_IDLE;
      endcase
   end

   // Broadcast controls for the row
   always_comb begin
      ctl          = '0;
      ctl.match_en = (phase_ff == PH_MATCH);
      ctl.pick_en  = (phase_ff == PH_PICK);
      ctl.apply_en = apply;
      ctl.any_key  = (op_ff == OP_DEQ);
      ctl.key      = key_ff;
      ctl.do_shift = (op_ff == OP_DEQ) | (op_ff == OP_REMOVE);
      ctl.do_enq   = (op_ff == OP_ENQ);
      ctl.enq_id   = key_ff;
      ctl.enq_desc = desc_ff;
   end

   assign hit[0] = 1'b0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic              left_v;
      logic              right_v;
      logic [ID_W-1:0]   right_i;
      logic [DESC_W-1:0] right_d;

      if (k == 0) begin : g_head
         assign left_v = 1'b1;
      end else begin : g_body
         assign left_v = cell_valid[k-1];
      end

      if (k == CAPACITY - 1) begin : g_tail
         assign right_v = 1'b0;
         assign right_i = '0;
         assign right_d = '0;
      end else begin : g_link
         assign right_v = cell_valid[k+1];
         assign right_i = cell_id[k+1];
         assign right_d = cell_desc[k+1];
      end

      prq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_valid  (left_v),
         .right_valid (right_v),
         .right_id    (right_i),
         .right_desc  (right_d),
         .hit_in      (hit[k]),
         .hit_out     (hit[k+1]),
         .valid       (cell_valid[k]),
         .id          (cell_id[k]),
         .desc        (cell_desc[k]),
         .sel_id      (sel_id[k]),
         .sel_desc    (sel_desc[k])
      );
   end

   // At most one cell marks itself first; OR the row together.
   always_comb begin
      pick_id   = '0;
      pick_desc = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         pick_id   = pick_id | sel_id[k];
         pick_desc = pick_desc | sel_desc[k];
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STAT_OK;
      unique case (op_ff)
         OP_ENQ: begin
            if (full) status_in = STAT_FULL;
            else      count_in  = count_ff + CNT_W'(1);
         end
         OP_DEQ: begin
            if (empty) status_in = STAT_EMPTY;
            else       count_in  = count_ff - CNT_W'(1);
         end
         OP_REMOVE: begin
            if (!any_hit_ff) status_in = STAT_NOTFOUND;
            else             count_in  = count_ff - CNT_W'(1);
         end
         OP_LOOKUP: begin
            if (!any_hit_ff) status_in = STAT_NOTFOUND;
         end
         default: status_in = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         any_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (phase_ff == PH_PICK) begin
            any_hit_ff <= hit[CAPACITY];
         end
         if (apply) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req.op);
         key_ff  <= req.proc_id;
         desc_ff <= req.descriptor;
      end
      if (apply) begin
         status_ff   <= status_in;
         out_id_ff   <= (op_ff == OP_ENQ) ? '0 : pick_id;
         out_desc_ff <= (op_ff == OP_ENQ) ? '0 : pick_desc;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.out_id         = out_id_ff;
   assign rsp.out_descriptor = out_desc_ff;
   assign rsp.occupancy      = $bits(rsp.occupancy)'(count_ff);

endmodule

// ----- rtl/prq_cell.sv -----
`timescale 1ns / 1ps

module prq_cell import prq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic              left_valid,
   input  logic              right_valid,
   input  logic [ID_W-1:0]   right_id,
   input  logic [DESC_W-1:0] right_desc,
   input  logic              hit_in,
   output logic              hit_out,
   output logic              valid,
   output logic [ID_W-1:0]   id,
   output logic [DESC_W-1:0] desc,
   output logic [ID_W-1:0]   sel_id,
   output logic [DESC_W-1:0] sel_desc
);

   logic              valid_ff;
   logic [ID_W-1:0]   id_ff;
   logic [DESC_W-1:0] desc_ff;
   logic              match_ff;
   logic              first_ff;
   logic              shift_ff;
   logic              take_right;
   logic              take_enq;

   assign hit_out    = hit_in | match_ff;
   assign take_right = ctl.apply_en & ctl.do_shift & shift_ff;
   assign take_enq   = ctl.apply_en & ctl.do_enq & ~valid_ff & left_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         first_ff <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         if (ctl.match_en) begin
            match_ff <= valid_ff & (ctl.any_key | (id_ff == ctl.key));
         end
         if (ctl.pick_en) begin
            first_ff <= match_ff & ~hit_in;
            shift_ff <= match_ff | hit_in;
         end
         if (take_right) begin
            valid_ff <= right_valid;
         end else if (take_enq) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // Entry payload: no reset, only read while valid.
   always_ff @(posedge clock) begin
      if (take_right) begin
         id_ff   <= right_id;
         desc_ff <= right_desc;
      end else if (take_enq) begin
         id_ff   <= ctl.enq_id;
         desc_ff <= ctl.enq_desc;
      end
   end

   assign valid    = valid_ff;
   assign id       = id_ff;
   assign desc     = desc_ff;
   assign sel_id   = first_ff ? id_ff : '0;
   assign sel_desc = first_ff ? desc_ff : '0;

endmodule

// ----- rtl/prq_checker.sv -----
`timescale 1ns / 1ps
`include "process_ready_queue_core_assert.svh"

module prq_checker import prq_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int OCC_W    = 5
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [ID_W-1:0]   rsp_out_id,
   input logic [OCC_W-1:0]  rsp_occupancy
);

   // A stalled result beat holds.
   `PRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_id))

   // One item in flight: no accept right after an accept.
   `PRQ_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   // Full is only reported with every cell occupied.
   `PRQ_ASSERT_NOW(a_full_occ, clock, reset, rsp_valid && (rsp_status == STAT_FULL), rsp_occupancy == OCC_W'(CAPACITY))

   // Empty means nothing held and nothing returned.
   `PRQ_ASSERT_NOW(a_empty_occ, clock, reset, rsp_valid && (rsp_status == STAT_EMPTY), (rsp_occupancy == '0) && (rsp_out_id == '0))

endmodule

bind process_ready_queue_core prq_checker #(
   .CAPACITY (CAPACITY),
   .OCC_W    ($bits(rsp.occupancy))
) u_prq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_status    (rsp.status),
   .rsp_out_id    (rsp.out_id),
   .rsp_occupancy (rsp.occupancy)
);

// ----- bench/prq_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the queue, predicts every
// response and compares it field by field with what the block returns.
module prq_result_checker import prq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   prq_req_if          req,
   prq_rsp_if          rsp,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   localparam int OCC_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   id;
      logic [DESC_W-1:0] desc;
      logic [OCC_W-1:0]  occ;
   } queue_result_type;

   logic [ID_W-1:0]   shadow_ids   [CAPACITY];
   logic [DESC_W-1:0] shadow_descs [CAPACITY];
   int                shadow_count;
   queue_result_type  pending_results [$];

   task automatic report_mismatch(string msg);
      $display("[%0t] queue check: %s", $time, msg);
      fail_count++;
   endtask

   // Close the gap at pos, keeping order.
   function automatic void drop_entry(int pos);
      for (int k = pos; k < shadow_count - 1; k++) begin
         shadow_ids[k]   = shadow_ids[k + 1];
         shadow_descs[k] = shadow_descs[k + 1];
      end
      shadow_count--;
   endfunction

   // Apply one operation to the shadow queue and return the response it owes.
   function automatic queue_result_type run_queue_op(op_type op, logic [ID_W-1:0] key,
                                                     logic [DESC_W-1:0] desc);
      queue_result_type res;
      int               hit;
      res.status = STAT_OK;
      res.id     = '0;
      res.desc   = '0;
      hit        = -1;
      case (op)
         OP_ENQ: begin
            if (shadow_count >= CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               shadow_ids[shadow_count]   = key;
               shadow_descs[shadow_count] = desc;
               shadow_count++;
            end
         end
         OP_DEQ: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.id   = shadow_ids[0];
               res.desc = shadow_descs[0];
               drop_entry(0);
            end
         end
         default: begin
            // Oldest match wins when identifiers repeat.
            for (int k = 0; k < shadow_count; k++) begin
               if (hit < 0 && shadow_ids[k] == key) hit = k;
            end
            if (hit < 0) begin
               res.status = STAT_NOTFOUND;
            end else begin
               res.id   = shadow_ids[hit];
               res.desc = shadow_descs[hit];
               if (op == OP_REMOVE) drop_entry(hit);
            end
         end
      endcase
      res.occ = OCC_W'(shadow_count);
      return res;
   endfunction

   task automatic check_result();
      queue_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("response beat with no request pending (status %0d)",
                                   rsp.status));
         return;
      end
      want = pending_results.pop_front();
      if (rsp.status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
      if (rsp.out_id !== want.id)
         report_mismatch($sformatf("out_id got %h want %h", rsp.out_id, want.id));
      if (rsp.out_descriptor !== want.desc)
         report_mismatch($sformatf("out_descriptor got %h want %h",
                                   rsp.out_descriptor, want.desc));
      if (rsp.occupancy !== want.occ)
         report_mismatch($sformatf("occupancy got %0d want %0d", rsp.occupancy, want.occ));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         pending_results.delete();
         fail_count = 0;
         outstanding <= 0;
      end else begin
         if (rsp.valid && rsp.ready) check_result();
         if (req.valid && req.ready)
            pending_results.push_back(run_queue_op(op_type'(req.op), req.proc_id,
                                                   req.descriptor));
         outstanding <= pending_results.size();
      end
   end

endmodule

// ----- bench/process_ready_queue_core_tb.sv -----
`timescale 1ns / 1ps

// Drives request beats into the ready queue, throttles the response side and
// gives the verdict. All prediction and comparison lives in the checker.
module process_ready_queue_core_tb import prq_pkg::*;;

   localparam int CAPACITY    = 16;
   localparam int RANDOM_OPS  = 500;
   localparam int QUIET_FROM  = 400;      // no idling on either side past this item
   localparam int HOLD_AFTER  = 60;       // start the long response stall here
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;
   bit          long_hold = 1'b0;

   logic [ID_W-1:0] id_pool [POOL_SIZE];

   prq_req_if req_ch ();
   prq_rsp_if rsp_ch ();

   process_ready_queue_core #(.CAPACITY(CAPACITY)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   prq_result_checker #(.CAPACITY(CAPACITY)) result_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Hold the time budget; trip if the run never drains.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: random stalls, one long stall to back the queue up, and
   // ready held high once the run goes quiet.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            long_hold = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Offer one beat and wait for the handshake; then maybe drop valid for a burst.
   task automatic send_item(op_type op, logic [ID_W-1:0] pid, logic [DESC_W-1:0] desc);
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.proc_id    <= pid;
      req_ch.descriptor <= desc;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      // Keep offering during the long stall so the block fills up.
      if (!quiet && !long_hold && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Mostly reuse a small set of identifiers so removes and lookups hit,
   // with duplicates; sometimes draw a fresh one.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 4) == 0) return ID_W'($urandom);
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   initial begin
      int      roll;
      bit      filling;
      op_type  op;
      logic [ID_W-1:0]   pid;
      logic [DESC_W-1:0] desc;

      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_ENQ;
      req_ch.proc_id    <= '0;
      req_ch.descriptor <= '0;
      for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: operations on an empty queue.
      send_item(OP_DEQ, 16'h0000, 32'h0);
      send_item(OP_REMOVE, 16'h0000, 32'h0);
      send_item(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);

      // Fill to capacity with extreme fields and a repeated identifier.
      for (int k = 0; k < CAPACITY; k++) begin
         pid  = (k == 1) ? 16'hFFFF : ((k % 5 == 2) ? 16'h1234 : ID_W'(k * 257));
         desc = (k == 0) ? 32'hFFFF_FFFF : ((k == CAPACITY - 1) ? 32'h0 : $urandom);
         send_item(OP_ENQ, pid, desc);
      end
      send_item(OP_ENQ, 16'hAAAA, 32'h5555_5555);   // queue full

      // Duplicates: lookup and remove act on the oldest match.
      send_item(OP_LOOKUP, 16'h1234, 32'h0);
      send_item(OP_REMOVE, 16'h1234, 32'h0);
      send_item(OP_LOOKUP, 16'h1234, 32'h0);
      send_item(OP_REMOVE, 16'hFFFF, 32'h0);
      send_item(OP_DEQ, 16'h0000, 32'h0);
      send_item(OP_REMOVE, 16'hBEEF, 32'h0);        // no match in a busy queue

      // Random: alternate fill-heavy and drain-heavy stretches so the queue
      // swings between full and empty.
      filling = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 50 == 0) filling = (n % 100 == 0);
         if (n == QUIET_FROM) quiet = 1'b1;
         roll = $urandom_range(0, 99);
         if (filling)
            op = (roll < 60) ? OP_ENQ : (roll < 75) ? OP_DEQ :
                 (roll < 85) ? OP_REMOVE : OP_LOOKUP;
         else
            op = (roll < 20) ? OP_ENQ : (roll < 65) ? OP_DEQ :
                 (roll < 85) ? OP_REMOVE : OP_LOOKUP;
         send_item(op, pick_id(), $urandom);
      end
      req_ch.valid <= 1'b0;

      // Drain: wait for every response, then let the pipeline settle.
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- process_ready_queue_core.f -----
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_if.sv
rtl/prq_cell.sv
rtl/process_ready_queue_core.sv
rtl/prq_checker.sv
bench/prq_result_checker.sv
bench/process_ready_queue_core_tb.sv
